// ===== rtl/core/cwbb_pkg.sv =====
// Shared types and constants for the color window bounding box block.
package cwbb_pkg;

  localparam int COLOR_W = 8;
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int INDEX_W = 3;

  // Largest frame dimension; wider settings saturate here.
  localparam int MAX_DIMENSION = 2048;

  localparam logic [INDEX_W-1:0] REG_TARGET_RED   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_TARGET_GREEN = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TARGET_BLUE  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_TOLERANCE    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [COLOR_W-1:0] RESET_TARGET_RED   = 8'd168;
  localparam logic [COLOR_W-1:0] RESET_TARGET_GREEN = 8'd69;
  localparam logic [COLOR_W-1:0] RESET_TARGET_BLUE  = 8'd46;
  localparam logic [COLOR_W-1:0] RESET_TOLERANCE    = 8'd45;
  localparam logic [DIM_W-1:0]   RESET_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]   RESET_IMAGE_HEIGHT = 12'd480;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

// ===== rtl/core/cwbb_ifs.sv =====
// Handshake interfaces for the pixel, box and configuration channels.
interface cwbb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source(output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink(input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface cwbb_box_if;
  logic        valid;
  logic        ready;
  logic [10:0] box_left;
  logic [10:0] box_right;
  logic [10:0] box_top;
  logic [10:0] box_bottom;
  logic        found;

  modport source(output valid, box_left, box_right, box_top, box_bottom, found,
                 input ready);
  modport sink(input valid, box_left, box_right, box_top, box_bottom, found,
               output ready);
endinterface

interface cwbb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/color_window_bounding_box.sv =====
// Top level: color window match and per-frame bounding box over a pixel stream.
//
//   channel | dir | handshake     | payload
//   pixel   | in  | valid/ready   | pixel_red, pixel_green, pixel_blue
//   box     | out | valid/ready   | box_left, box_right, box_top, box_bottom, found
//   cfg     | in  | valid/ready   | index, data (ready always high)
//
// One pixel item per cycle unless a frame end waits on a stalled box sink.
// The input register feeds the compare and box update; the box register
// holds the result while the sink stalls, and pixels that end no frame keep flowing.
// Synchronous reset restores the register defaults and clears counters and box.
module color_window_bounding_box (
  input logic           clk,
  input logic           rst,
  cwbb_pixel_if.sink    pixel,
  cwbb_box_if.source    box,
  cwbb_cfg_if.sink      cfg
);
  import cwbb_pkg::*;

  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] OneDim = DIM_W'(1);

  // configuration
  color_t             target;
  logic [COLOR_W-1:0] tolerance;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  // input register
  logic   s1_valid;
  color_t s1_pixel;

  // frame state
  logic [COORD_W-1:0] column_count;
  logic [COORD_W-1:0] row_count;
  logic [COORD_W-1:0] least_column;
  logic [COORD_W-1:0] greatest_column;
  logic [COORD_W-1:0] least_row;
  logic [COORD_W-1:0] greatest_row;
  logic               any_match;

  // result register
  logic               out_valid;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_right;
  logic [COORD_W-1:0] out_top;
  logic [COORD_W-1:0] out_bottom;
  logic               out_found;

  logic               match;
  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic [DIM_W-1:0]   column_inc;
  logic [DIM_W-1:0]   row_inc;
  logic               last_col;
  logic               frame_end;
  logic               advance;
  logic [COORD_W-1:0] least_column_next;
  logic [COORD_W-1:0] greatest_column_next;
  logic [COORD_W-1:0] least_row_next;
  logic [COORD_W-1:0] greatest_row_next;
  logic               any_match_next;

  cwbb_match u_match (
    .pixel     (s1_pixel),
    .target    (target),
    .tolerance (tolerance),
    .match     (match)
  );

  always_comb begin
    width_eff  = (image_width == '0) ? OneDim :
                 (image_width > MaxDim) ? MaxDim : image_width;
    height_eff = (image_height == '0) ? OneDim :
                 (image_height > MaxDim) ? MaxDim : image_height;
    column_inc = {1'b0, column_count} + OneDim;
    row_inc    = {1'b0, row_count} + OneDim;
    last_col   = column_inc >= width_eff;
    frame_end  = last_col && (row_inc >= height_eff);
    advance    = s1_valid && (!frame_end || !out_valid || box.ready);

    least_column_next    = least_column;
    greatest_column_next = greatest_column;
    least_row_next       = least_row;
    greatest_row_next    = greatest_row;
    any_match_next       = any_match;
    if (match) begin
      if (column_count < least_column) least_column_next = column_count;
      if (column_count > greatest_column) greatest_column_next = column_count;
      if (row_count < least_row) least_row_next = row_count;
      if (row_count > greatest_row) greatest_row_next = row_count;
      any_match_next = 1'b1;
    end
  end

  assign pixel.ready = !s1_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target.red   <= RESET_TARGET_RED;
      target.green <= RESET_TARGET_GREEN;
      target.blue  <= RESET_TARGET_BLUE;
      tolerance    <= RESET_TOLERANCE;
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TARGET_RED:   target.red   <= cfg.data[COLOR_W-1:0];
        REG_TARGET_GREEN: target.green <= cfg.data[COLOR_W-1:0];
        REG_TARGET_BLUE:  target.blue  <= cfg.data[COLOR_W-1:0];
        REG_TOLERANCE:    tolerance    <= cfg.data[COLOR_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      s1_pixel.red   <= pixel.pixel_red;
      s1_pixel.green <= pixel.pixel_green;
      s1_pixel.blue  <= pixel.pixel_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      least_column    <= '1;
      greatest_column <= '0;
      least_row       <= '1;
      greatest_row    <= '0;
      any_match       <= 1'b0;
    end else if (advance) begin
      if (frame_end) begin
        column_count    <= '0;
        row_count       <= '0;
        least_column    <= '1;
        greatest_column <= '0;
        least_row       <= '1;
        greatest_row    <= '0;
        any_match       <= 1'b0;
      end else begin
        least_column    <= least_column_next;
        greatest_column <= greatest_column_next;
        least_row       <= least_row_next;
        greatest_row    <= greatest_row_next;
        any_match       <= any_match_next;
        if (last_col) begin
          column_count <= '0;
          row_count    <= row_inc[COORD_W-1:0];
        end else begin
          column_count <= column_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && frame_end) begin
      out_valid <= 1'b1;
    end else if (box.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      out_found  <= any_match_next;
      out_left   <= any_match_next ? least_column_next : '0;
      out_right  <= any_match_next ? greatest_column_next : '0;
      out_top    <= any_match_next ? least_row_next : '0;
      out_bottom <= any_match_next ? greatest_row_next : '0;
    end
  end

  assign box.valid      = out_valid;
  assign box.box_left   = out_left;
  assign box.box_right  = out_right;
  assign box.box_top    = out_top;
  assign box.box_bottom = out_bottom;
  assign box.found      = out_found;

endmodule

// ===== rtl/core/cwbb_match.sv =====
// Per-channel color window compare against the target color.
module cwbb_match (
  input  cwbb_pkg::color_t                 pixel,
  input  cwbb_pkg::color_t                 target,
  input  logic [cwbb_pkg::COLOR_W-1:0]     tolerance,
  output logic                             match
);
  import cwbb_pkg::*;

  logic [COLOR_W-1:0] diff_red;
  logic [COLOR_W-1:0] diff_green;
  logic [COLOR_W-1:0] diff_blue;

  always_comb begin
    diff_red   = (pixel.red >= target.red) ? pixel.red - target.red
                                           : target.red - pixel.red;
    diff_green = (pixel.green >= target.green) ? pixel.green - target.green
                                               : target.green - pixel.green;
    diff_blue  = (pixel.blue >= target.blue) ? pixel.blue - target.blue
                                             : target.blue - pixel.blue;
    match = (diff_red <= tolerance) && (diff_green <= tolerance) &&
            (diff_blue <= tolerance);
  end

endmodule

// ===== rtl/core/cwbb_checker.sv =====
// Port-level checks on the box channel, bound to the top level.
module cwbb_checker (
  input logic        clk,
  input logic        rst,
  input logic        box_valid,
  input logic        box_ready,
  input logic [10:0] box_left,
  input logic [10:0] box_right,
  input logic [10:0] box_top,
  input logic [10:0] box_bottom,
  input logic        found
);

  a_reset_clears_box: assert property (@(posedge clk)
    $past(rst) |-> !box_valid)
    else $error("box valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_ready |=> box_valid && $stable(box_left) &&
      $stable(box_right) && $stable(box_top) && $stable(box_bottom) &&
      $stable(found))
    else $error("box item changed while stalled");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    box_valid && !found |-> box_left == 11'd0 && box_right == 11'd0 &&
      box_top == 11'd0 && box_bottom == 11'd0)
    else $error("box fields nonzero with nothing found");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box_valid && found |-> box_left <= box_right && box_top <= box_bottom)
    else $error("box edges out of order");

endmodule

bind color_window_bounding_box cwbb_checker u_cwbb_checker (
  .clk        (clk),
  .rst        (rst),
  .box_valid  (box.valid),
  .box_ready  (box.ready),
  .box_left   (box.box_left),
  .box_right  (box.box_right),
  .box_top    (box.box_top),
  .box_bottom (box.box_bottom),
  .found      (box.found)
);
